>>> rtl/core/hcbp_pkg.sv
// Shared types, field widths and action codes for the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int SYMBOL_COUNT_DEF  = 256;

    localparam int ACTION_W      = 2;
    localparam int SYMBOL_W      = 8;
    localparam int CODE_VALUE_W  = 32;
    localparam int CODE_LENGTH_W = 6;
    localparam int BYTE_W        = 8;
    localparam int HELD_W        = 7;
    localparam int HELD_CNT_W    = 3;

    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

    typedef struct packed {
        logic [CODE_VALUE_W-1:0]  value;
        logic [CODE_LENGTH_W-1:0] length;
    } lookup_t;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [CODE_VALUE_W-1:0]  value;
        logic [CODE_LENGTH_W-1:0] length;
    } pk_req_t;

endpackage

`default_nettype wire

>>> rtl/core/hcbp_code_table.sv
// Code table memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_code_table #(
    parameter int SYMBOL_COUNT  = hcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_DEF,
    parameter int IDX_W         = $clog2(SYMBOL_COUNT)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               wr_en,
    input  wire logic [IDX_W-1:0]                   wr_idx,
    input  wire logic [hcbp_pkg::CODE_VALUE_W-1:0]  wr_value,
    input  wire logic [hcbp_pkg::CODE_LENGTH_W-1:0] wr_length,
    input  wire logic                               rd_en,
    input  wire logic [IDX_W-1:0]                   rd_idx,
    output hcbp_pkg::lookup_t                       rd_data
);
    import hcbp_pkg::*;

    logic [CODE_VALUE_W-1:0]  value_mem [SYMBOL_COUNT];
    logic [CODE_LENGTH_W-1:0] length_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]  valid_reg;
    logic [CODE_LENGTH_W-1:0] sat_length;
    logic [CODE_VALUE_W-1:0]  rd_value_reg;
    logic [CODE_LENGTH_W-1:0] rd_length_reg;
    logic                     rd_valid_reg;

    always_comb begin
        if (32'(wr_length) > MAX_CODE_BITS) begin
            sat_length = CODE_LENGTH_W'(MAX_CODE_BITS);
        end else begin
            sat_length = wr_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_mem[wr_idx]  <= wr_value;
            length_mem[wr_idx] <= sat_length;
        end
        if (rd_en) begin
            rd_value_reg  <= value_mem[rd_idx];
            rd_length_reg <= length_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    // unwritten entries read as zero length
    assign rd_data.value  = rd_value_reg;
    assign rd_data.length = rd_valid_reg ? rd_length_reg : '0;

endmodule

`default_nettype wire

>>> rtl/core/hcbp_packer.sv
// Bit accumulator and byte emitter that drives the result channel.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer #(
    parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         req_valid,
    input  wire hcbp_pkg::pk_req_t            req,
    output logic                              req_ready,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_last
);
    import hcbp_pkg::*;

    localparam int ACC_W     = MAX_CODE_BITS + HELD_W;
    localparam int MAX_BYTES = (ACC_W + BYTE_W - 1) / BYTE_W;
    localparam int EMIT_W    = MAX_BYTES * BYTE_W;
    localparam int TOT_W     = $clog2(ACC_W + 1);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int SH_W      = $clog2(EMIT_W + 1);

    logic [HELD_W-1:0]     held_bits_reg, held_bits_next;
    logic [HELD_CNT_W-1:0] held_cnt_reg, held_cnt_next;
    logic [EMIT_W-1:0]     emit_reg, emit_next;
    logic [CNT_W-1:0]      left_reg, left_next;

    logic [ACC_W-1:0]      acc;
    logic [TOT_W-1:0]      total;
    logic [SH_W-1:0]       sh;
    logic [HELD_CNT_W-1:0] fsh;
    logic [BYTE_W-1:0]     flush_byte;
    logic                  take;

    assign req_ready = (left_reg == '0) || ((left_reg == CNT_W'(1)) && m_ready);
    assign take      = req_valid && req_ready;

    always_comb begin
        acc = (ACC_W'(held_bits_reg) << req.length)
            | (ACC_W'(req.value) & ~({ACC_W{1'b1}} << req.length));
        total      = TOT_W'(held_cnt_reg) + TOT_W'(req.length);
        sh         = SH_W'(EMIT_W) - SH_W'(total);
        fsh        = HELD_CNT_W'(0) - held_cnt_reg;
        flush_byte = BYTE_W'({1'b0, held_bits_reg} << fsh);

        held_bits_next = held_bits_reg;
        held_cnt_next  = held_cnt_reg;
        emit_next      = emit_reg;
        left_next      = left_reg;

        if (m_valid && m_ready) begin
            emit_next = emit_reg << BYTE_W;
            left_next = left_reg - CNT_W'(1);
        end

        if (take) begin
            case (req.action)
                ACT_ENCODE: begin
                    emit_next      = EMIT_W'(acc) << sh;
                    left_next      = CNT_W'(total >> 3);
                    held_bits_next = HELD_W'(acc & ~({ACC_W{1'b1}} << total[2:0]));
                    held_cnt_next  = total[2:0];
                end
                ACT_FLUSH: begin
                    emit_next      = EMIT_W'(flush_byte) << (EMIT_W - BYTE_W);
                    left_next      = (held_cnt_reg != '0) ? CNT_W'(1) : '0;
                    held_bits_next = '0;
                    held_cnt_next  = '0;
                end
                default: begin
                    left_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        emit_reg <= emit_next;
        if (!aresetn) begin
            held_bits_reg <= '0;
            held_cnt_reg  <= '0;
            left_reg      <= '0;
        end else begin
            held_bits_reg <= held_bits_next;
            held_cnt_reg  <= held_cnt_next;
            left_reg      <= left_next;
        end
    end

    assign m_valid    = (left_reg != '0);
    assign m_last     = (left_reg == CNT_W'(1));
    assign m_out_byte = emit_reg[EMIT_W-1 -: BYTE_W];

endmodule

`default_nettype wire

>>> rtl/core/huffman_code_bit_packer_unit.sv
// Top level of the Huffman code bit packer: table lookup stage and byte packer.
//
//  channel | direction | ports                                         | beat
//  s_      | in        | s_action s_symbol s_code_value s_code_length  | one action
//  m_      | out       | m_out_byte m_last                             | one packed byte
//
// An accepted beat reads the code table in that cycle and reaches the packer
// in the next cycle. An encode yields 0 to 4 bytes, one per cycle while m_ready
// is high. Actions giving at most one byte flow at one beat per cycle on the
// same condition. Reset clears the table valid bits, held bits and control at
// once; no clearing pass. Output stalls back up through s_ready.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_DEF,
    parameter int SYMBOL_COUNT  = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [hcbp_pkg::ACTION_W-1:0]      s_action,
    input  wire logic [hcbp_pkg::SYMBOL_W-1:0]      s_symbol,
    input  wire logic [hcbp_pkg::CODE_VALUE_W-1:0]  s_code_value,
    input  wire logic [hcbp_pkg::CODE_LENGTH_W-1:0] s_code_length,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]             m_out_byte,
    output logic                                    m_last
);
    import hcbp_pkg::*;

    localparam int IDX_W = $clog2(SYMBOL_COUNT);

    logic                s_accept;
    logic                in_range;
    logic                st1_valid_reg;
    logic [ACTION_W-1:0] st1_action_reg;
    logic                st1_in_range_reg;
    lookup_t             lookup;
    pk_req_t             req;
    logic                req_ready;

    assign in_range = (32'(s_symbol) < SYMBOL_COUNT);
    assign s_accept = s_valid && s_ready;
    assign s_ready  = !st1_valid_reg || req_ready;

    hcbp_code_table #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .IDX_W         (IDX_W)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (s_accept && (s_action == ACT_LOAD) && in_range),
        .wr_idx    (s_symbol[IDX_W-1:0]),
        .wr_value  (s_code_value),
        .wr_length (s_code_length),
        .rd_en     (s_accept),
        .rd_idx    (s_symbol[IDX_W-1:0]),
        .rd_data   (lookup)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_action_reg   <= s_action;
            st1_in_range_reg <= in_range;
        end
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    assign req.action = st1_action_reg;
    assign req.value  = lookup.value;
    assign req.length = st1_in_range_reg ? lookup.length : '0;

    hcbp_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (st1_valid_reg),
        .req        (req),
        .req_ready  (req_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

>>> rtl/core/hcbp_checker.sv
// Port-level assertions for the Huffman code bit packer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_last
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_byte) && $stable(m_last))
        else $error("result payload changed while stalled");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("byte burst ended without last");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_last     (m_last)
);

`default_nettype wire

>>> bench/hcbp_stream_checker.sv
// Stream checker for the code bit packer: predicts packed bytes and compares them.
`timescale 1ns / 1ps

module hcbp_stream_checker
    import hcbp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic [ACTION_W-1:0]      s_action,
    input  wire logic [SYMBOL_W-1:0]      s_symbol,
    input  wire logic [CODE_VALUE_W-1:0]  s_code_value,
    input  wire logic [CODE_LENGTH_W-1:0] s_code_length,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic [BYTE_W-1:0]        m_out_byte,
    input  wire logic                     m_last,
    output int                            fail_count,
    output int                            pending
);

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    logic [CODE_VALUE_W-1:0]  code_val_tbl [SYMBOL_COUNT_DEF];
    logic [CODE_LENGTH_W-1:0] code_len_tbl [SYMBOL_COUNT_DEF];
    logic [HELD_W-1:0]        held_bits;
    logic [HELD_CNT_W-1:0]    held_count;
    packed_byte_t             due_bytes [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic clear_packer();
        for (int i = 0; i < SYMBOL_COUNT_DEF; i++) begin
            code_val_tbl[i] = '0;
            code_len_tbl[i] = '0;
        end
        held_bits  = '0;
        held_count = '0;
        due_bytes.delete();
    endtask

    task automatic pack_code_bits(input logic [ACTION_W-1:0] act,
                                  input logic [SYMBOL_W-1:0] sym,
                                  input logic [CODE_VALUE_W-1:0] val,
                                  input logic [CODE_LENGTH_W-1:0] len);
        logic [63:0] acc;
        int          total;
        int          clen;
        packed_byte_t nb;
        case (act)
            ACT_LOAD: begin
                code_val_tbl[sym] = val;
                code_len_tbl[sym] = (len > MAX_CODE_BITS_DEF) ?
                                    CODE_LENGTH_W'(MAX_CODE_BITS_DEF) : len;
            end
            ACT_ENCODE: begin
                clen = int'(code_len_tbl[sym]);
                if (clen != 0) begin
                    acc = (64'(held_bits) << clen) |
                          (64'(code_val_tbl[sym]) & ((64'd1 << clen) - 64'd1));
                    total = int'(held_count) + clen;
                    while (total >= 8) begin
                        total   -= 8;
                        nb.data  = 8'(acc >> total);
                        nb.last  = (total < 8);
                        due_bytes.push_back(nb);
                    end
                    held_bits  = HELD_W'(acc & ((64'd1 << total) - 64'd1));
                    held_count = HELD_CNT_W'(total);
                end
            end
            ACT_FLUSH: begin
                if (held_count != 0) begin
                    nb.data = 8'({1'b0, held_bits} << (8 - int'(held_count)));
                    nb.last = 1'b1;
                    due_bytes.push_back(nb);
                    held_bits  = '0;
                    held_count = '0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        packed_byte_t exp_b;
        if (!aresetn) begin
            clear_packer();
        end else begin
            if (m_valid && m_ready) begin
                if (due_bytes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h last %0b",
                                            m_out_byte, m_last));
                end else begin
                    exp_b = due_bytes.pop_front();
                    if (m_out_byte !== exp_b.data)
                        flag_mismatch($sformatf("out_byte %02h, want %02h",
                                                m_out_byte, exp_b.data));
                    if (m_last !== exp_b.last)
                        flag_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                                m_last, exp_b.last, exp_b.data));
                end
            end
            if (s_valid && s_ready)
                pack_code_bits(s_action, s_symbol, s_code_value, s_code_length);
        end
        pending = due_bytes.size();
    end

endmodule

>>> bench/huffman_code_bit_packer_unit_test.sv
// Top of the code bit packer bench: clock, reset, beat stimulus and verdict.
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_test;
    import hcbp_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 500;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [ACTION_W-1:0]      s_action;
    logic [SYMBOL_W-1:0]      s_symbol;
    logic [CODE_VALUE_W-1:0]  s_code_value;
    logic [CODE_LENGTH_W-1:0] s_code_length;
    logic                     m_valid;
    logic                     m_ready;
    logic [BYTE_W-1:0]        m_out_byte;
    logic                     m_last;

    int fail_count;
    int pending;
    int sender_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    bit long_hold_due;
    bit loaded [SYMBOL_COUNT_DEF];
    logic [SYMBOL_W-1:0] known_syms [$];

    huffman_code_bit_packer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_symbol      (s_symbol),
        .s_code_value  (s_code_value),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last)
    );

    hcbp_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_symbol      (s_symbol),
        .s_code_value  (s_code_value),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_beat(input logic [ACTION_W-1:0] act,
                             input logic [SYMBOL_W-1:0] sym,
                             input logic [CODE_VALUE_W-1:0] val,
                             input logic [CODE_LENGTH_W-1:0] len);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_symbol      <= sym;
        s_code_value  <= val;
        s_code_length <= len;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (act == ACT_LOAD && !loaded[sym]) begin
            loaded[sym] = 1'b1;
            known_syms.push_back(sym);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        int                       sent;
        int                       roll;
        int                       pick;
        logic [ACTION_W-1:0]      act;
        logic [SYMBOL_W-1:0]      sym;
        logic [CODE_LENGTH_W-1:0] len;

        long_hold_due   = 1'b0;
        sender_idle_pct = 23;
        recv_idle_pct   = 51;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_action        = ACT_LOAD;
        s_symbol        = '0;
        s_code_value    = '0;
        s_code_length   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_beat(ACT_ENCODE, 8'h00, 32'h0, 6'h00);
        send_beat(ACT_FLUSH,  8'h00, 32'h0, 6'h00);
        send_beat(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_beat(ACT_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_beat(ACT_LOAD,   8'h00, 32'h0000_0000, 6'd1);
        send_beat(ACT_LOAD,   8'h01, 32'h1234_5678, 6'd32);
        send_beat(ACT_LOAD,   8'h02, 32'hFFFF_FF5A, 6'd7);
        send_beat(ACT_LOAD,   8'hA5, 32'h0000_0005, 6'd3);
        send_beat(ACT_LOAD,   8'h03, 32'hDEAD_BEEF, 6'd0);
        send_beat(ACT_LOAD,   8'h80, 32'hCAFE_F00D, 6'd33);
        send_beat(ACT_ENCODE, 8'hFF, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'h00, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'hFF, 32'h0, 6'h00);
        send_beat(ACT_FLUSH,  8'h00, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'h02, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'h01, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'h03, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'hA5, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'h80, 32'h0, 6'h00);
        send_beat(ACT_FLUSH,  8'h00, 32'h0, 6'h00);
        send_beat(ACT_FLUSH,  8'h00, 32'h0, 6'h00);
        send_beat(ACT_ENCODE, 8'h55, 32'h0, 6'h00);

        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                wait_drained();
                sender_idle_pct = 51;
                recv_idle_pct   = 23;
            end else if (phase == 2) begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
                long_hold_due   = 1'b1;
            end
            while (sent < (RANDOM_ITEMS * (phase + 1)) / 3) begin
                roll = $urandom_range(99);
                sym  = $urandom_range(255);
                len  = $urandom_range(63);
                if (roll < 14) begin
                    act  = ACT_LOAD;
                    pick = $urandom_range(19);
                    if (pick == 0)
                        len = 6'd0;
                    else if (pick == 1)
                        len = $urandom_range(63, 33);
                    else if (pick < 5)
                        len = $urandom_range(32, 13);
                    else
                        len = $urandom_range(12, 1);
                end else if (roll < 82) begin
                    act = ACT_ENCODE;
                    if (known_syms.size() > 0 && $urandom_range(9) != 0)
                        sym = known_syms[$urandom_range(known_syms.size() - 1)];
                end else if (roll < 96) begin
                    act = ACT_FLUSH;
                end else begin
                    act = ACT_UNUSED;
                end
                send_beat(act, sym, $urandom, len);
                if (act != ACT_UNUSED)
                    sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_code_table.sv
rtl/core/hcbp_packer.sv
rtl/core/huffman_code_bit_packer_unit.sv
rtl/core/hcbp_checker.sv
bench/hcbp_stream_checker.sv
bench/huffman_code_bit_packer_unit_test.sv
